### rtl/bgm_pkg.sv
// Shared types and constants for the bit-granular memory-move block.
// Holds the transaction payload structs, the opcode codes and the
// controller/datapath command and status structs. Depends on nothing.
`timescale 1ns / 1ps

package bgm_pkg;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_COPY   = 2'd2;
    localparam logic [1:0] OP_IGNORE = 2'd3;

    localparam logic [2:0] BIT_TOP  = 3'd7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [9:0]  byte_address;
        logic [7:0]  write_data;
        logic [12:0] source_bit_address;
        logic [12:0] dest_bit_address;
        logic [13:0] bit_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic bit_rd;
        logic bit_wr;
        logic read_done;
    } bgm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic read_go;
        logic copy_go;
        logic last_bit;
    } bgm_stat_t;

endpackage

### rtl/bgm_ctrl.sv
// Controller state machine for the bit-granular memory-move block.
// Sequences accept, byte read, per-bit copy and result hold. Uses bgm_pkg.
`timescale 1ns / 1ps

module bgm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bgm_pkg::bgm_stat_t stat,
    output bgm_pkg::bgm_cmd_t  cmd
);
    import bgm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_READ    = 5'b00010,
        S_COPY_RD = 5'b00100,
        S_COPY_WR = 5'b01000,
        S_DONE    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);

    always_comb
    begin
        cmd.accept    = in_valid && (state_reg == S_IDLE);
        cmd.bit_rd    = (state_reg == S_COPY_RD);
        cmd.bit_wr    = (state_reg == S_COPY_WR);
        cmd.read_done = (state_reg == S_READ);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.read_go)
                        state_next = S_READ;
                    else if (stat.copy_go)
                        state_next = S_COPY_RD;
                    else
                        state_next = S_DONE;
                end
            end
            S_READ:    state_next = S_DONE;
            S_COPY_RD: state_next = S_COPY_WR;
            S_COPY_WR: state_next = stat.last_bit ? S_DONE : S_COPY_RD;
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/bgm_datapath.sv
// Datapath of the bit-granular memory-move block: byte memory, copy
// address counters, bit merge and result register. Uses bgm_pkg.
`timescale 1ns / 1ps

module bgm_datapath #(
    parameter int MEM_BYTES = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bgm_pkg::in_item_t   in_item,
    input  bgm_pkg::bgm_cmd_t   cmd,
    output bgm_pkg::bgm_stat_t  stat,
    output bgm_pkg::out_item_t  out_item
);
    import bgm_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int PW = AW + 3;
    localparam logic [31:0] TOTAL_BITS = 32'(MEM_BYTES) * 32'd8;

    logic [7:0]    mem [MEM_BYTES];

    logic [PW-1:0] src_pos_reg, dst_pos_reg;
    logic [13:0]   remain_reg;
    logic          fwd_reg;
    logic [7:0]    src_byte_reg, dst_byte_reg;
    logic [7:0]    rdata_reg;
    logic          status_reg;

    logic [31:0]   src_end, dst_end, src_start, dst_start;
    logic          range_bad, addr_ok, fwd;
    logic [AW-1:0] byte_idx, src_idx, dst_idx;
    logic          src_bit;
    logic [7:0]    dst_mask, merged;

    always_comb
    begin
        src_end   = 32'(in_item.source_bit_address) + 32'(in_item.bit_count);
        dst_end   = 32'(in_item.dest_bit_address) + 32'(in_item.bit_count);
        range_bad = (src_end > TOTAL_BITS) || (dst_end > TOTAL_BITS);
        addr_ok   = 32'(in_item.byte_address) < 32'(MEM_BYTES);
        fwd       = in_item.dest_bit_address < in_item.source_bit_address;
        // A backward copy starts at the last bit of each range.
        src_start = fwd ? 32'(in_item.source_bit_address) : src_end - 32'd1;
        dst_start = fwd ? 32'(in_item.dest_bit_address) : dst_end - 32'd1;
        byte_idx  = AW'(in_item.byte_address);

        stat.read_go  = (in_item.opcode == OP_READ) && addr_ok;
        stat.copy_go  = (in_item.opcode == OP_COPY) && !range_bad
                        && (in_item.bit_count != 14'd0)
                        && (in_item.source_bit_address != in_item.dest_bit_address);
        stat.last_bit = (remain_reg == 14'd1);

        src_idx  = src_pos_reg[PW-1:3];
        dst_idx  = dst_pos_reg[PW-1:3];
        src_bit  = src_byte_reg[BIT_TOP - src_pos_reg[2:0]];
        dst_mask = 8'h80 >> dst_pos_reg[2:0];
        merged   = src_bit ? (dst_byte_reg | dst_mask) : (dst_byte_reg & ~dst_mask);
    end

    // Memory with one write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (in_item.opcode == OP_WRITE) && addr_ok)
            mem[byte_idx] <= in_item.write_data;
        else if (cmd.bit_wr)
            mem[dst_idx] <= merged;

        if (cmd.accept)
            src_byte_reg <= mem[byte_idx];
        else if (cmd.bit_rd)
        begin
            src_byte_reg <= mem[src_idx];
            dst_byte_reg <= mem[dst_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_pos_reg <= '0;
            dst_pos_reg <= '0;
            remain_reg  <= 14'd0;
            fwd_reg     <= 1'b0;
            rdata_reg   <= 8'd0;
            status_reg  <= 1'b0;
        end
        else if (cmd.accept)
        begin
            src_pos_reg <= PW'(src_start);
            dst_pos_reg <= PW'(dst_start);
            remain_reg  <= in_item.bit_count;
            fwd_reg     <= fwd;
            rdata_reg   <= 8'd0;
            if ((in_item.opcode == OP_WRITE) || (in_item.opcode == OP_READ))
                status_reg <= !addr_ok;
            else if (in_item.opcode == OP_COPY)
                status_reg <= range_bad;
            else
                status_reg <= 1'b0;
        end
        else if (cmd.bit_wr)
        begin
            src_pos_reg <= fwd_reg ? src_pos_reg + PW'(1) : src_pos_reg - PW'(1);
            dst_pos_reg <= fwd_reg ? dst_pos_reg + PW'(1) : dst_pos_reg - PW'(1);
            remain_reg  <= remain_reg - 14'd1;
        end
        else if (cmd.read_done)
            rdata_reg <= src_byte_reg;
    end

    assign out_item.read_data = rdata_reg;
    assign out_item.status    = status_reg;

endmodule

### rtl/bit_granular_memmove.sv
// Bit-granular byte memory with byte write, byte read and overlap-safe bit copy.
// A write or a flagged/ignored item goes straight to the result; a read passes
// through a read state first; a copy does one read and one write of the memory per bit.
// One transaction at a time: a new item is accepted only after the result is taken.
// Reset clears only the control and result registers; memory is undefined until written.
`timescale 1ns / 1ps

module bit_granular_memmove #(
    parameter int MEM_BYTES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bgm_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output bgm_pkg::out_item_t out_item
);
    import bgm_pkg::*;

    bgm_cmd_t  cmd;
    bgm_stat_t stat;

    // The controller decides the sequence; the datapath owns memory and counters.
    bgm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // A copy walks bit by bit, ascending when the destination lies below the
    // source and descending otherwise, so overlapping ranges behave like memmove.
    bgm_datapath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (out_item)
    );

endmodule
